[src/fog_factor_table_generator_defines.svh]
// Assertion macros shared by the fog factor table generator RTL.
// FOGG_ASSERT expects clk and arst_n in the scope of use; FOGG_ASSERT_ALWAYS expects clk.
`ifndef FOG_FACTOR_TABLE_GENERATOR_DEFINES_SVH
`define FOG_FACTOR_TABLE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define FOGG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FOGG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FOGG_ASSERT(lbl, prop, msg)
`define FOGG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/fogg_pkg.sv]
`default_nettype none
package fogg_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int LOG2_TE = $clog2(TABLE_ENTRIES);
	localparam int IDX_W = 9;
	localparam int DEN_W = 24;
	localparam int OPA_W = 17;
	localparam int VAL_W = 17;
	localparam int MODE_W = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int PROD_W = DEN_W + IDX_W + 4;
	localparam int T_W = 25;
	localparam int SQ_W = 2 * T_W;
	localparam int U_W = 33;
	localparam int ACC_W = 31;
	localparam int E_W = 30;
	localparam int NUM_W = 14;
	localparam int AD_W = 24;
	localparam int AN_MAX = (TABLE_ENTRIES > 511) ? TABLE_ENTRIES : 511;
	localparam int DVD_W = $clog2(((AN_MAX * 65536) / TABLE_ENTRIES) + 1);
	localparam int EXP_STEPS = 16;
	localparam int DIV_FIRST = 2;
	localparam int EXP_FIRST = 3;
	localparam int EXP_LAST = EXP_FIRST + EXP_STEPS - 1;
	localparam int DIV_LAST = DIV_FIRST + DVD_W - 1;
	localparam int LAST_STEP = (EXP_LAST > DIV_LAST) ? EXP_LAST : DIV_LAST;
	localparam int ST_BLEND = LAST_STEP + 1;
	localparam int ST_OUT = ST_BLEND + 1;
	localparam int NS = ST_OUT + 1;

	localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);
	localparam logic [U_W-1:0] EXP_LIMIT = U_W'(12 * 65536);

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_DENSITY = 2'd1;
	localparam logic [1:0] REG_OPACITY = 2'd2;

	localparam logic [MODE_W-1:0] RST_MODE = '0;
	localparam logic [DEN_W-1:0] RST_DENSITY = DEN_W'(65536);
	localparam logic [OPA_W-1:0] RST_OPACITY = OPA_W'(65536);

	typedef enum logic [1:0] {
		MODE_EXP  = 2'd0,
		MODE_EXP2 = 2'd1,
		MODE_LIN  = 2'd2,
		MODE_NONE = 2'd3
	} fog_mode_t;

	typedef enum logic [1:0] {
		LIN_ZERO = 2'd0,
		LIN_ONE  = 2'd1,
		LIN_DIV  = 2'd2
	} lin_kind_t;

	typedef struct packed {
		fog_mode_t mode;
		logic [DEN_W-1:0] density;
		logic [OPA_W-1:0] opacity;
	} cfg_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [T_W-1:0] t;
		logic [SQ_W-1:0] sq;
		logic [ACC_W-1:0] acc;
		logic [15:0] frac;
		logic uflow;
		lin_kind_t kind;
		logic [AD_W-1:0] ad;
		logic [DVD_W-1:0] dvd;
		logic [AD_W-1:0] rem;
		logic [DVD_W-1:0] quo;
		logic [2*VAL_W-1:0] pm;
		logic [VAL_W-1:0] fog;
	} stage_t;

	// exp(-n) in Q30
	function automatic logic [ACC_W-1:0] int_exp(input logic [3:0] n);
		case (n)
			4'd0: int_exp = ACC_W'(1073741824);
			4'd1: int_exp = ACC_W'(395007542);
			4'd2: int_exp = ACC_W'(145315153);
			4'd3: int_exp = ACC_W'(53458454);
			4'd4: int_exp = ACC_W'(19666267);
			4'd5: int_exp = ACC_W'(7234816);
			4'd6: int_exp = ACC_W'(2661540);
			4'd7: int_exp = ACC_W'(979126);
			4'd8: int_exp = ACC_W'(360200);
			4'd9: int_exp = ACC_W'(132510);
			4'd10: int_exp = ACC_W'(48748);
			4'd11: int_exp = ACC_W'(17933);
			default: int_exp = '0;
		endcase
	endfunction

	// exp(-2^-k) in Q30
	function automatic logic [E_W-1:0] frac_exp(input int k);
		case (k)
			1: frac_exp = E_W'(651257337);
			2: frac_exp = E_W'(836230973);
			3: frac_exp = E_W'(947573834);
			4: frac_exp = E_W'(1008687096);
			5: frac_exp = E_W'(1040706261);
			6: frac_exp = E_W'(1057095000);
			7: frac_exp = E_W'(1065385899);
			8: frac_exp = E_W'(1069555701);
			9: frac_exp = E_W'(1071646719);
			10: frac_exp = E_W'(1072693760);
			11: frac_exp = E_W'(1073217664);
			12: frac_exp = E_W'(1073479712);
			13: frac_exp = E_W'(1073610760);
			14: frac_exp = E_W'(1073676290);
			15: frac_exp = E_W'(1073709056);
			16: frac_exp = E_W'(1073725440);
			default: frac_exp = E_W'(1073741823);
		endcase
	endfunction

endpackage
`default_nettype wire

[src/fogg_if.sv]
`default_nettype none
interface fogg_idx_if;
	logic valid;
	logic ready;
	logic [fogg_pkg::IDX_W-1:0] entry_index;
	modport source (output valid, output entry_index, input ready);
	modport sink (input valid, input entry_index, output ready);
endinterface

interface fogg_val_if;
	logic valid;
	logic ready;
	logic [fogg_pkg::VAL_W-1:0] fog_value;
	modport source (output valid, output fog_value, input ready);
	modport sink (input valid, input fog_value, output ready);
endinterface
`default_nettype wire

[src/fogg_regs.sv]
`default_nettype none
module fogg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fogg_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [fogg_pkg::DATA_W-1:0]   pwdata,
	output logic      [fogg_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output fogg_pkg::cfg_t                     cfg
);

	fogg_pkg::cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= fogg_pkg::fog_mode_t'(fogg_pkg::RST_MODE);
			cfg_q.density <= fogg_pkg::RST_DENSITY;
			cfg_q.opacity <= fogg_pkg::RST_OPACITY;
		end else if (wr) begin
			case (paddr[3:2])
				fogg_pkg::REG_MODE: begin
					cfg_q.mode <= fogg_pkg::fog_mode_t'(pwdata[fogg_pkg::MODE_W-1:0]);
				end
				fogg_pkg::REG_DENSITY: begin
					cfg_q.density <= pwdata[fogg_pkg::DEN_W-1:0];
				end
				fogg_pkg::REG_OPACITY: begin
					cfg_q.opacity <= pwdata[fogg_pkg::OPA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			fogg_pkg::REG_MODE: prdata = fogg_pkg::DATA_W'(cfg_q.mode);
			fogg_pkg::REG_DENSITY: prdata = fogg_pkg::DATA_W'(cfg_q.density);
			fogg_pkg::REG_OPACITY: prdata = fogg_pkg::DATA_W'(cfg_q.opacity);
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[src/fog_factor_table_generator.sv]
// Fog factor table generator.
// idx_ch (sink) takes one entry_index per transaction; val_ch (source) returns
// one fog_value (Q1.16, 65536 = no fog) per transaction, in order.
// Mode, density and opacity are set through the APB-style port at byte
// addresses 0, 4 and 8; write them only while no transaction is in flight.
// The datapath is a 21-stage pipeline: product, square, exp seed, sixteen
// exp refinement multiplies (with the linear-mode restoring divider running
// one quotient bit per stage beside them), blend multiply, output round.
// One index is accepted per cycle while val_ch is not stalled, so throughput
// is one result per clock.
// When val_ch stalls the whole pipeline holds and idx_ch.ready drops while
// the output register is full; nothing is lost or repeated.
// Reset empties the pipeline and sets mode exponential, density 1.0 and
// opacity 1.0.
`default_nettype none
`include "fog_factor_table_generator_defines.svh"
module fog_factor_table_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fogg_idx_if.sink                           idx_ch,
	fogg_val_if.source                         val_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fogg_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [fogg_pkg::DATA_W-1:0]   pwdata,
	output logic      [fogg_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);

	localparam int NS = fogg_pkg::NS;

	fogg_pkg::cfg_t cfg;
	fogg_pkg::stage_t pipe_s [NS];
	fogg_pkg::stage_t nxt [NS];
	logic vld_s [NS];
	logic adv;

	fogg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv = !vld_s[NS-1] || val_ch.ready;
	assign idx_ch.ready = adv;
	assign val_ch.valid = vld_s[NS-1];
	assign val_ch.fog_value = pipe_s[NS-1].fog;

	always_comb begin
		logic signed [fogg_pkg::NUM_W-1:0] num;
		logic signed [fogg_pkg::DEN_W+1:0] den;
		logic [fogg_pkg::NUM_W-1:0] an;
		logic [fogg_pkg::DEN_W+1:0] adf;
		logic [29:0] dvdw;
		logic [fogg_pkg::PROD_W-1:0] tr;
		logic [fogg_pkg::SQ_W:0] sqr;
		logic [fogg_pkg::U_W-1:0] u;
		logic [60:0] mp;
		logic [fogg_pkg::AD_W:0] r;
		logic [fogg_pkg::DVD_W-1:0] qs;
		logic [fogg_pkg::VAL_W-1:0] vv;
		logic [2*fogg_pkg::VAL_W:0] pr;
		logic [fogg_pkg::VAL_W+1:0] p;
		int k;
		int b;

		nxt[0] = '0;
		nxt[0].prod = fogg_pkg::PROD_W'(idx_ch.entry_index * 13'd10)
			* fogg_pkg::PROD_W'(cfg.density);
		num = $signed(fogg_pkg::NUM_W'(fogg_pkg::TABLE_ENTRIES))
			- $signed({{(fogg_pkg::NUM_W-fogg_pkg::IDX_W){1'b0}}, idx_ch.entry_index});
		den = $signed((fogg_pkg::DEN_W+2)'(65536)) - $signed({2'b00, cfg.density});
		an = (num < 0) ? fogg_pkg::NUM_W'(-num) : fogg_pkg::NUM_W'(num);
		adf = (den < 0) ? (fogg_pkg::DEN_W+2)'(-den) : (fogg_pkg::DEN_W+2)'(den);
		dvdw = (30'(an) << 16) >> fogg_pkg::LOG2_TE;
		nxt[0].ad = adf[fogg_pkg::AD_W-1:0];
		nxt[0].dvd = dvdw[fogg_pkg::DVD_W-1:0];
		if (den == 0) begin
			nxt[0].kind = (num > 0) ? fogg_pkg::LIN_ONE : fogg_pkg::LIN_ZERO;
		end else if (num == 0 || ((num > 0) != (den > 0))) begin
			nxt[0].kind = fogg_pkg::LIN_ZERO;
		end else begin
			nxt[0].kind = fogg_pkg::LIN_DIV;
		end

		for (int i = 1; i < NS; i++) begin
			nxt[i] = pipe_s[i-1];
			if (i == 1) begin
				tr = pipe_s[i-1].prod >> fogg_pkg::LOG2_TE;
				nxt[i].t = (tr > fogg_pkg::PROD_W'(1 << 24)) ? fogg_pkg::T_W'(1 << 24)
					: tr[fogg_pkg::T_W-1:0];
				nxt[i].sq = fogg_pkg::SQ_W'(nxt[i].t) * fogg_pkg::SQ_W'(nxt[i].t);
			end
			if (i == 2) begin
				sqr = {1'b0, pipe_s[i-1].sq} + (fogg_pkg::SQ_W+1)'(32768);
				u = (cfg.mode == fogg_pkg::MODE_EXP2) ? sqr[48:16]
					: fogg_pkg::U_W'(pipe_s[i-1].t);
				nxt[i].uflow = (u >= fogg_pkg::EXP_LIMIT);
				nxt[i].acc = fogg_pkg::int_exp(u[19:16]);
				nxt[i].frac = u[15:0];
			end
			if (i >= fogg_pkg::EXP_FIRST && i <= fogg_pkg::EXP_LAST) begin
				k = i - fogg_pkg::EXP_FIRST + 1;
				mp = 61'(pipe_s[i-1].acc) * 61'(fogg_pkg::frac_exp(k)) + (61'd1 << 29);
				if (pipe_s[i-1].frac[16-k]) begin
					nxt[i].acc = mp[60:30];
				end
			end
			if (i >= fogg_pkg::DIV_FIRST && i <= fogg_pkg::DIV_LAST) begin
				b = fogg_pkg::DVD_W - 1 - (i - fogg_pkg::DIV_FIRST);
				r = {pipe_s[i-1].rem, pipe_s[i-1].dvd[b]};
				if (r >= {1'b0, pipe_s[i-1].ad}) begin
					r = r - {1'b0, pipe_s[i-1].ad};
					nxt[i].quo[b] = 1'b1;
				end
				nxt[i].rem = r[fogg_pkg::AD_W-1:0];
			end
			if (i == fogg_pkg::ST_BLEND) begin
				qs = pipe_s[i-1].quo;
				case (cfg.mode)
					fogg_pkg::MODE_EXP, fogg_pkg::MODE_EXP2: begin
						mp = 61'(pipe_s[i-1].acc) + 61'd8192;
						vv = pipe_s[i-1].uflow ? '0 : fogg_pkg::VAL_W'(mp[60:14]);
					end
					fogg_pkg::MODE_LIN: begin
						case (pipe_s[i-1].kind)
							fogg_pkg::LIN_ONE: vv = fogg_pkg::ONE_Q16;
							fogg_pkg::LIN_DIV: begin
								vv = (fogg_pkg::DVD_W'(qs) > fogg_pkg::DVD_W'(65536))
									? fogg_pkg::ONE_Q16 : fogg_pkg::VAL_W'(qs);
							end
							default: vv = '0;
						endcase
					end
					default: vv = fogg_pkg::ONE_Q16;
				endcase
				nxt[i].pm = (2*fogg_pkg::VAL_W)'(fogg_pkg::ONE_Q16 - vv)
					* (2*fogg_pkg::VAL_W)'(cfg.opacity);
			end
			if (i == fogg_pkg::ST_OUT) begin
				pr = {1'b0, pipe_s[i-1].pm} + (2*fogg_pkg::VAL_W+1)'(32768);
				p = pr[2*fogg_pkg::VAL_W:16];
				nxt[i].fog = (p > (fogg_pkg::VAL_W+2)'(65536)) ? '0
					: fogg_pkg::VAL_W'((fogg_pkg::VAL_W+2)'(65536) - p);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= idx_ch.valid;
			for (int i = 1; i < NS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NS; i++) begin
				pipe_s[i] <= nxt[i];
			end
		end
	end

	`FOGG_ASSERT_ALWAYS(a_out_range, val_ch.valid |-> (val_ch.fog_value <= fogg_pkg::ONE_Q16), "fog value above one")
	`FOGG_ASSERT(a_accept_enters, (idx_ch.valid && idx_ch.ready) |=> vld_s[0], "accepted index lost at entry")
	`FOGG_ASSERT(a_acc_bound, vld_s[fogg_pkg::EXP_LAST] |-> (pipe_s[fogg_pkg::EXP_LAST].acc <= fogg_pkg::ACC_W'(1 << 30)), "exp accumulator above one")
	`FOGG_ASSERT(a_div_rem, (vld_s[fogg_pkg::DIV_LAST] && (pipe_s[fogg_pkg::DIV_LAST].kind == fogg_pkg::LIN_DIV)) |-> (pipe_s[fogg_pkg::DIV_LAST].rem < pipe_s[fogg_pkg::DIV_LAST].ad), "divider remainder not below divisor")

endmodule
`default_nettype wire
